>>> src/mvs_pkg.sv
// Package for the valve supervisor: item types, codes and constants.
`timescale 1ns / 1ps
package mvs_pkg;

  localparam int FAULT_WIDTH_DEF = 16;
  localparam int TIMEOUT_MS_W = 26;

  localparam logic [15:0] TIMEOUT_DEFAULT_S = 16'd30;
  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam logic [TIMEOUT_MS_W-1:0] TIMEOUT_DEFAULT_MS = TIMEOUT_MS_W'(30000);

  typedef enum logic [2:0] {
    CMD_SAMPLE      = 3'd0,
    CMD_STOP        = 3'd1,
    CMD_OPEN        = 3'd2,
    CMD_CLOSE       = 3'd3,
    CMD_EMERGENCY   = 3'd4,
    CMD_ENTER_MAN   = 3'd5,
    CMD_LEAVE_MAN   = 3'd6,
    CMD_CLEAR_LATCH = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    VS_UNKNOWN   = 4'd0,
    VS_OPEN      = 4'd1,
    VS_CLOSED    = 4'd2,
    VS_OPENING   = 4'd3,
    VS_CLOSING   = 4'd4,
    VS_JAMMED    = 4'd5,
    VS_TIMEOUT   = 4'd6,
    VS_MANUAL    = 4'd7,
    VS_EMERGENCY = 4'd8
  } valve_state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        open_limit;
    logic        closed_limit;
    logic        overcurrent;
    logic        manual_switch;
    logic [63:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  valve_state;
    logic        motor_open;
    logic        motor_close;
    logic        latch_set;
    logic [15:0] faults;
    logic [63:0] motion_start;
    logic [63:0] motion_deadline;
  } out_item_t;

endpackage

>>> src/mvs_in_reg.sv
// Input register stage: holds one accepted beat until the core takes it.
`timescale 1ns / 1ps
module mvs_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  mvs_pkg::in_item_t item,
  input  logic             advance,
  output logic             held_valid,
  output mvs_pkg::in_item_t held
);
  import mvs_pkg::*;

  logic valid;

  assign item_ready = !valid || advance;
  assign held_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

>>> src/mvs_ctrl.sv
// Supervisor state and its one-pass update for a command or sample beat.
`timescale 1ns / 1ps
module mvs_ctrl #(
  parameter int FAULT_WIDTH = mvs_pkg::FAULT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              advance,
  input  mvs_pkg::in_item_t  item,
  output mvs_pkg::out_item_t result_next
);
  import mvs_pkg::*;

  valve_state_t               mode, mode_next;
  logic                       open_drive, open_next;
  logic                       close_drive, close_next;
  logic                       latch, latch_next;
  logic [FAULT_WIDTH-1:0]     fault_total, fault_next;
  logic [63:0]                start_time, start_next;
  logic [63:0]                deadline_time, deadline_next;
  logic [TIMEOUT_MS_W-1:0]    timeout_ms;
  logic [15:0]                secs;
  logic [63:0]                deadline_cand;
  logic                       in_manual;
  logic                       do_halt, do_start, toward_open, do_count;
  valve_state_t               set_mode;
  logic                       set_mode_en;

  // Timeout in ms is formed at the register write, off the item path.
  assign secs = (cfg_data == 16'd0) ? TIMEOUT_DEFAULT_S : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_DEFAULT_MS;
    end else if (cfg_we) begin
      timeout_ms <= TIMEOUT_MS_W'(secs) * TIMEOUT_MS_W'(MS_PER_S);
    end
  end

  assign deadline_cand = item.now_ms + 64'(timeout_ms);
  assign in_manual = (mode == VS_MANUAL);

  // Decide what the beat does.
  always_comb begin
    do_halt = 1'b0;
    do_start = 1'b0;
    toward_open = 1'b0;
    do_count = 1'b0;
    set_mode = mode;
    set_mode_en = 1'b0;
    latch_next = latch;
    case (cmd_t'(item.cmd))
      CMD_SAMPLE: begin
        if (item.manual_switch && !in_manual) begin
          do_halt = 1'b1;
          set_mode = VS_MANUAL;
          set_mode_en = 1'b1;
        end else if (in_manual) begin
          // hold everything while in manual
        end else if (item.open_limit && item.closed_limit) begin
          do_halt = 1'b1;
          set_mode = VS_JAMMED;
          set_mode_en = 1'b1;
          do_count = 1'b1;
        end else if (item.overcurrent && (open_drive || close_drive)) begin
          do_halt = 1'b1;
          set_mode = VS_JAMMED;
          set_mode_en = 1'b1;
          do_count = 1'b1;
        end else if (mode == VS_OPENING && item.open_limit) begin
          do_halt = 1'b1;
          set_mode = VS_OPEN;
          set_mode_en = 1'b1;
        end else if ((mode inside {VS_CLOSING, VS_EMERGENCY}) && item.closed_limit) begin
          do_halt = 1'b1;
          set_mode = VS_CLOSED;
          set_mode_en = 1'b1;
        end else if (deadline_time != 64'd0 && item.now_ms >= deadline_time) begin
          do_halt = 1'b1;
          set_mode = VS_TIMEOUT;
          set_mode_en = 1'b1;
          do_count = 1'b1;
        end
      end
      CMD_STOP: begin
        do_halt = 1'b1;
        set_mode = VS_UNKNOWN;
        set_mode_en = 1'b1;
      end
      CMD_OPEN: begin
        if (!latch && !in_manual) begin
          do_start = 1'b1;
          toward_open = 1'b1;
          set_mode = VS_OPENING;
          set_mode_en = 1'b1;
        end
      end
      CMD_CLOSE: begin
        if (!in_manual) begin
          do_start = 1'b1;
          set_mode = VS_CLOSING;
          set_mode_en = 1'b1;
        end
      end
      CMD_EMERGENCY: begin
        latch_next = 1'b1;
        do_start = 1'b1;
        set_mode = VS_EMERGENCY;
        set_mode_en = 1'b1;
      end
      CMD_ENTER_MAN: begin
        do_halt = 1'b1;
        set_mode = VS_MANUAL;
        set_mode_en = 1'b1;
      end
      CMD_LEAVE_MAN: begin
        if (in_manual) begin
          set_mode = VS_UNKNOWN;
          set_mode_en = 1'b1;
        end
      end
      CMD_CLEAR_LATCH: begin
        latch_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Next state of the registers.
  always_comb begin
    mode_next = set_mode_en ? set_mode : mode;
    open_next = open_drive;
    close_next = close_drive;
    start_next = start_time;
    deadline_next = deadline_time;
    fault_next = do_count ? fault_total + 1'b1 : fault_total;
    if (do_halt) begin
      open_next = 1'b0;
      close_next = 1'b0;
      start_next = 64'd0;
      deadline_next = 64'd0;
    end else if (do_start) begin
      open_next = toward_open;
      close_next = !toward_open;
      start_next = item.now_ms;
      deadline_next = deadline_cand;
    end
  end

  // Result fields show the state after the beat.
  always_comb begin
    result_next.valve_state = mode_next;
    result_next.motor_open = open_next;
    result_next.motor_close = close_next;
    result_next.latch_set = latch_next;
    result_next.faults = 16'(fault_next);
    result_next.motion_start = start_next;
    result_next.motion_deadline = deadline_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= VS_UNKNOWN;
      open_drive <= 1'b0;
      close_drive <= 1'b0;
      latch <= 1'b0;
      fault_total <= '0;
      start_time <= 64'd0;
      deadline_time <= 64'd0;
    end else if (advance) begin
      mode <= mode_next;
      open_drive <= open_next;
      close_drive <= close_next;
      latch <= latch_next;
      fault_total <= fault_next;
      start_time <= start_next;
      deadline_time <= deadline_next;
    end
  end

endmodule

>>> src/motor_valve_supervisor.sv
// Motorized valve supervisor: top level with input stage, core and result register.
// Usage:
//   Items arrive on item/item_valid/item_ready; each is a command or a sensor
//   sample (limit switches, overcurrent, manual switch, time in ms).
//   Each accepted beat produces exactly one result beat on
//   result/result_valid/result_ready: the valve state after that item.
//   cfg_we/cfg_data write the motion timeout in seconds (zero means 30);
//   write only while no item is in flight.
// Path: an accepted beat waits in the input stage until the result register is
//   free or being read; then the same edge updates the state and loads the
//   result register.
// Throughput: one item per cycle while result_ready is high; the state update,
//   one 64-bit add for the deadline and one 64-bit compare, is combinational.
// Reset (rst, synchronous): state unknown, drives off, latch clear, fault
//   count zero, timeout 30 s, both stages empty.
// Stall: when result_ready is low the result register holds; the input stage
//   still takes one more beat, then item_ready drops until the result moves.
`timescale 1ns / 1ps
module motor_valve_supervisor #(
  parameter int FAULT_WIDTH = mvs_pkg::FAULT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  mvs_pkg::in_item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output mvs_pkg::out_item_t  result
);
  import mvs_pkg::*;

  logic      held_valid;
  in_item_t  held;
  logic      advance;
  out_item_t result_next;
  logic      out_valid;

  // Move the held beat into the result register when it is empty or being read.
  assign advance = held_valid && (!out_valid || result_ready);
  assign result_valid = out_valid;

  mvs_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  mvs_ctrl #(
    .FAULT_WIDTH (FAULT_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .advance     (advance),
    .item        (held),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule
